// ===== rtl/me_pkg.sv =====
// ============================================================================
// Modular exponentiation package
// Shared widths, register indexes and types for the exponentiation block.
// ============================================================================
`default_nettype none

package me_pkg;

   localparam int WORD_BITS        = 32;
   localparam int MOD_BITS_DEFAULT = 32;
   localparam int CSR_INDEX_BITS   = 2;

   typedef logic [WORD_BITS-1:0]      word_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_EXPONENT = 2'd0;
   localparam csr_index_type CSR_MODULUS  = 2'd1;

endpackage : me_pkg

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// ============================================================================
// Modular exponentiation
// Right-to-left square and multiply: message ** exponent mod modulus, with
// one multiplier and one shared bit-serial remainder unit.
//
//   Channel   Ports                           Handshake
//   request   start, busy, req_message        taken when start & !busy
//   response  rsp_valid, rsp_power_result     one-cycle strobe, no stall
//   csr       csr_valid, csr_ready, csr_index, csr_wdata   valid & ready
//
// A zero exponent or zero modulus answers on the cycle after start.
// Otherwise every step is one reduction in the shared remainder unit, which
// runs through all DIV_BITS dividend bits (64 at the default width); an item
// needs 1 + t + p reductions, t being the index of the exponent's top set
// bit and p its number of set bits: at most 64 reductions.
// Reset is synchronous and leaves exponent 0 and modulus 1. The receiver
// cannot stall; busy is low again in the cycle the response strobe is shown.
// ============================================================================
`default_nettype none

module modular_exponentiation #(
   parameter int MOD_BITS = me_pkg::MOD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire me_pkg::word_type      req_message,
   output logic                       rsp_valid,
   output me_pkg::word_type           rsp_power_result,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire me_pkg::csr_index_type csr_index,
   input  wire me_pkg::word_type      csr_wdata
);

   import me_pkg::*;

   localparam int PROD_BITS = 2 * MOD_BITS;
   localparam int DIV_BITS  = (PROD_BITS > WORD_BITS) ? PROD_BITS : WORD_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_BASE = 3'd1;
   localparam logic [2:0] S_STEP = 3'd2;
   localparam logic [2:0] S_RED  = 3'd3;

   logic [2:0]          state_ff, state_in;
   word_type            exponent_ff, exponent_in;
   word_type            modulus_ff, modulus_in;
   word_type            exp_ff, exp_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] base_ff, base_in;
   logic                sel_acc_ff, sel_acc_in;
   logic                acc_done_ff, acc_done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   word_type            result_ff, result_in;

   logic [MOD_BITS-1:0] mod_use;
   logic                sel_acc;
   logic [MOD_BITS-1:0] mul_a;
   logic [PROD_BITS-1:0] product;
   logic                rem_start;
   logic [DIV_BITS-1:0] rem_dividend;
   logic                rem_done;
   logic [MOD_BITS-1:0] rem_value;

   assign mod_use   = modulus_ff[MOD_BITS-1:0];
   assign csr_ready = 1'b1;

   // Register writes are to arrive only while the block is idle; the block itself does not enforce this.
   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EXPONENT: exponent_in = csr_wdata;
            CSR_MODULUS:  modulus_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // Multiply the accumulator by the base when the current bit is set,
   // otherwise square the base; the remainder unit registers the product.
   assign sel_acc = exp_ff[0] && !acc_done_ff;
   assign mul_a   = sel_acc ? acc_ff : base_ff;
   assign product = PROD_BITS'(mul_a) * PROD_BITS'(base_ff);

   assign rem_dividend = (state_ff == S_IDLE) ? DIV_BITS'(req_message)
                                              : DIV_BITS'(product);

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      sel_acc_in   = sel_acc_ff;
      acc_done_in  = acc_done_ff;
      rsp_valid_in = 1'b0;
      result_in    = result_ff;
      rem_start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (exponent_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  result_in    = WORD_BITS'(1);
               end else if (mod_use == '0) begin
                  rsp_valid_in = 1'b1;
                  result_in    = '0;
               end else begin
                  rem_start = 1'b1;
                  exp_in    = exponent_ff;
                  state_in  = S_BASE;
               end
            end
         end
         S_BASE: begin
            if (rem_done) begin
               base_in     = rem_value;
               acc_in      = MOD_BITS'(1);
               acc_done_in = 1'b0;
               state_in    = S_STEP;
            end
         end
         S_STEP: begin
            if (!sel_acc && exp_ff[WORD_BITS-1:1] == '0) begin
               rsp_valid_in = 1'b1;
               result_in    = WORD_BITS'(acc_ff);
               state_in     = S_IDLE;
            end else begin
               rem_start  = 1'b1;
               sel_acc_in = sel_acc;
               state_in   = S_RED;
            end
         end
         S_RED: begin
            if (rem_done) begin
               if (sel_acc_ff) begin
                  acc_in      = rem_value;
                  acc_done_in = 1'b1;
               end else begin
                  base_in     = rem_value;
                  exp_in      = exp_ff >> 1;
                  acc_done_in = 1'b0;
               end
               state_in = S_STEP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         exponent_ff  <= '0;
         modulus_ff   <= WORD_BITS'(1);
         rsp_valid_ff <= 1'b0;
         acc_done_ff  <= 1'b0;
         sel_acc_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exponent_ff  <= exponent_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_done_ff  <= acc_done_in;
         sel_acc_ff   <= sel_acc_in;
      end
      exp_ff    <= exp_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      result_ff <= result_in;
   end

   me_rem #(
      .MOD_BITS (MOD_BITS),
      .DIV_BITS (DIV_BITS)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .modulus   (mod_use),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = result_ff;

   a_busy_nonzero_mod: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> mod_use != '0)
      else $error("exponentiation running with a zero modulus");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      rem_done |-> (state_ff == S_RED || state_ff == S_BASE))
      else $error("remainder returned while no reduction was awaited");

   a_step_has_bits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STEP |-> exp_ff != '0)
      else $error("step taken with no exponent bits left");

endmodule : modular_exponentiation

`default_nettype wire

// ===== rtl/me_rem.sv =====
// ============================================================================
// Bit-serial remainder unit
// Restoring reduction of a dividend modulo the modulus, one dividend bit
// per cycle. A pulse on start loads the operands; done pulses with the
// remainder valid.
// ============================================================================
`default_nettype none

module me_rem #(
   parameter int MOD_BITS = 32,
   parameter int DIV_BITS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DIV_BITS-1:0] dividend,
   input  wire logic [MOD_BITS-1:0] modulus,
   output logic                     done,
   output logic [MOD_BITS-1:0]      remainder
);

   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS-1:0] dvd_ff, dvd_in;
   logic [MOD_BITS-1:0] rem_ff, rem_in;

   logic [MOD_BITS:0]   trial;
   logic [MOD_BITS:0]   diff;
   logic                fits;

   // The partial remainder stays below the modulus, so the trial value
   // stays below twice the modulus and one subtraction restores it.
   assign trial = {rem_ff, dvd_ff[DIV_BITS-1]};
   assign diff  = trial - {1'b0, modulus};
   assign fits  = trial >= {1'b0, modulus};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_BITS'(DIV_BITS);
         dvd_in    = dividend;
         rem_in    = '0;
      end else if (active_ff) begin
         rem_in = fits ? diff[MOD_BITS-1:0] : trial[MOD_BITS-1:0];
         dvd_in = {dvd_ff[DIV_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_done_after_work: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(active_ff))
      else $error("remainder done without a reduction in progress");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> cnt_ff != '0)
      else $error("reduction active with an exhausted bit count");

   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < modulus)
      else $error("remainder not below the modulus");

endmodule : me_rem

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Modular exponentiation testbench
// Writes exponent and modulus settings while the block is idle, sends
// directed and random messages under changing sender gaps, and checks each
// power result against a square-and-multiply predictor kept in step with the
// register writes.
// ============================================================================

module testbench;

   import me_pkg::*;

   localparam int MOD_BITS     = MOD_BITS_DEFAULT;
   localparam int ITEMS_TARGET = 270;
   localparam int STALL_LIMIT  = 30000;
   localparam int SETTLE_CYCLES = 100;
   localparam logic [63:0] MOD_MASK = (64'd1 << MOD_BITS) - 64'd1;

   // Indexes that decode to no register.
   localparam csr_index_type CSR_SPARE_LO = 2'd2;
   localparam csr_index_type CSR_SPARE_HI = 2'd3;

   typedef enum logic [1:0] {JOB_MESSAGE, JOB_CSR_WRITE, JOB_DRAIN} job_kind_type;

   typedef struct {
      job_kind_type  kind;
      csr_index_type index;
      word_type      data;
   } job_type;

   typedef struct {
      word_type message;
      word_type power;
   } power_expect_type;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          start       = 1'b0;
   logic          busy;
   word_type      req_message = '0;
   logic          rsp_valid;
   word_type      rsp_power_result;
   logic          csr_valid   = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index   = CSR_EXPONENT;
   word_type      csr_wdata   = '0;

   job_type          job_q[$];
   power_expect_type power_q[$];

   word_type cfg_exponent = '0;
   word_type cfg_modulus  = 32'd1;
   int       n_issued     = 0;
   int       n_done       = 0;
   int       total_items  = 0;
   int       errors       = 0;
   int       idle_count   = 0;

   modular_exponentiation #(
      .MOD_BITS(MOD_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_message     (req_message),
      .rsp_valid       (rsp_valid),
      .rsp_power_result(rsp_power_result),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Right-to-left square and multiply over the current register copies.
   function automatic word_type expected_power(word_type message);
      logic [63:0] m;
      logic [63:0] base;
      logic [63:0] acc;
      if (cfg_exponent == '0) return 32'd1;
      m = {32'd0, cfg_modulus} & MOD_MASK;
      if (m == 64'd0) return 32'd0;
      base = {32'd0, message} % m;
      acc  = 64'd1;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (cfg_exponent[b]) acc = (acc * base) % m;
         base = (base * base) % m;
      end
      return acc[WORD_BITS-1:0];
   endfunction

   task automatic add_message(input word_type message);
      job_q.push_back('{JOB_MESSAGE, CSR_EXPONENT, message});
      total_items++;
   endtask

   task automatic add_csr(input csr_index_type index, input word_type data);
      job_q.push_back('{JOB_CSR_WRITE, index, data});
   endtask

   task automatic add_setting(input word_type exponent, input word_type modulus);
      add_csr(CSR_EXPONENT, exponent);
      add_csr(CSR_MODULUS, modulus);
   endtask

   task automatic add_drain();
      job_q.push_back('{JOB_DRAIN, CSR_EXPONENT, '0});
   endtask

   // Driver: works through the job queue. Register writes and drains wait
   // until the block is idle and every expected result has arrived.
   always @(posedge clock) begin : drive_proc
      logic item_taken;
      logic csr_taken;
      logic quiet;
      logic nxt_start;
      logic nxt_csr_valid;
      int   idle_pct;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         item_taken = start && !busy;
         csr_taken  = csr_valid && csr_ready;
         if (item_taken || csr_taken) job_q.delete(0);
         quiet = !start && !busy && (n_issued == n_done);
         if (n_issued < total_items / 3) idle_pct = 29;
         else if (n_issued < 2 * total_items / 3) idle_pct = 79;
         else idle_pct = 0;
         nxt_start     = 1'b0;
         nxt_csr_valid = 1'b0;
         if (job_q.size() != 0) begin
            case (job_q[0].kind)
               JOB_MESSAGE: begin
                  // A raised start is held until the block takes it.
                  if ((start && !item_taken) ||
                      ((item_taken || !busy) && $urandom_range(99) >= idle_pct)) begin
                     nxt_start = 1'b1;
                     req_message <= job_q[0].data;
                  end
               end
               JOB_CSR_WRITE: begin
                  if ((csr_valid && !csr_taken) || quiet) begin
                     nxt_csr_valid = 1'b1;
                     csr_index <= job_q[0].index;
                     csr_wdata <= job_q[0].data;
                  end
               end
               default: begin
                  if (quiet) job_q.delete(0);
               end
            endcase
         end
         start     <= nxt_start;
         csr_valid <= nxt_csr_valid;
      end
   end

   // Monitor: checks results, predicts accepted messages, tracks register
   // writes and watches for a stalled run.
   always @(posedge clock) begin : check_proc
      power_expect_type want;
      logic             accepted;
      if (reset) begin
         cfg_exponent = '0;
         cfg_modulus  = 32'd1;
         idle_count  <= 0;
      end else begin
         accepted = 1'b0;
         if (rsp_valid) begin
            accepted = 1'b1;
            if (power_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: power_result %h", rsp_power_result);
            end else begin
               want = power_q.pop_front();
               n_done <= n_done + 1;
               if (rsp_power_result !== want.power) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: message %h power_result expected %h got %h",
                              want.message, want.power, rsp_power_result);
               end
            end
         end
         if (start && !busy) begin
            accepted      = 1'b1;
            want.message  = req_message;
            want.power    = expected_power(req_message);
            power_q.push_back(want);
            n_issued <= n_issued + 1;
         end
         if (csr_valid && csr_ready) begin
            accepted = 1'b1;
            case (csr_index)
               CSR_EXPONENT: cfg_exponent = csr_wdata;
               CSR_MODULUS:  cfg_modulus  = csr_wdata;
               default: ;
            endcase
         end
         if (accepted) begin
            idle_count <= 0;
         end else if (idle_count >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            idle_count <= idle_count + 1;
         end
      end
   end

   initial begin : stimulus_proc
      word_type exponent;
      word_type modulus;
      word_type message;
      int       run_len;

      // Reset values: exponent zero gives 1 for every message.
      add_message(32'h0000_0000);
      add_message(32'hFFFF_FFFF);
      // Exponent zero with a zero modulus still gives 1.
      add_csr(CSR_MODULUS, 32'd0);
      add_message(32'd5);
      // Largest exponent and modulus.
      add_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_message(32'h0000_0000);
      add_message(32'h0000_0001);
      add_message(32'hFFFF_FFFF);
      add_message(32'hFFFF_FFFE);
      // A modulus of one reduces everything to zero.
      add_csr(CSR_MODULUS, 32'd1);
      add_message(32'd12345);
      // A zero modulus with a nonzero exponent answers zero.
      add_csr(CSR_MODULUS, 32'd0);
      add_message(32'd7);
      // Writes to unused indexes must change nothing.
      add_csr(CSR_SPARE_LO, 32'hFFFF_FFFF);
      add_csr(CSR_SPARE_HI, 32'h0000_0000);
      add_message(32'hFFFF_FFFF);
      // Small textbook key.
      add_setting(32'd65537, 32'd3233);
      add_message(32'd65);
      add_message(32'd3232);
      add_message(32'd3233);
      add_message(32'hFFFF_FFFF);
      add_drain();
      add_setting(32'd1, 32'h8000_0000);
      add_message(32'hFFFF_FFFF);
      add_message(32'h8000_0000);
      add_setting(32'd2, 32'hFFFF_FFFB);
      add_message(32'hFFFF_FFFA);

      while (total_items < ITEMS_TARGET) begin
         case ($urandom_range(5))
            0:       exponent = '0;
            1:       exponent = $urandom_range(16, 1);
            2:       exponent = $urandom_range(1) ? 32'd3 : 32'd65537;
            3:       exponent = $urandom >> $urandom_range(31);
            4:       exponent = 32'hFFFF_FFFF;
            default: exponent = $urandom;
         endcase
         case ($urandom_range(9))
            0:       modulus = $urandom_range(255, 1);
            1:       modulus = $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
            2:       modulus = '0;
            3, 4:    modulus = $urandom;
            default: modulus = $urandom | 32'h8000_0001;
         endcase
         if ($urandom_range(5) == 0)
            add_csr(($urandom_range(1) != 0) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom);
         if ($urandom_range(3) == 0) begin
            add_csr(CSR_EXPONENT, exponent);
         end else begin
            add_setting(exponent, modulus);
         end
         run_len = $urandom_range(24, 6);
         for (int i = 0; i < run_len; i++) begin
            case ($urandom_range(9))
               6:       message = (modulus != '0) ? $urandom % modulus : $urandom;
               7:       message = modulus - 32'd1;
               8:       message = modulus;
               9:       message = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : $urandom_range(1);
               default: message = $urandom;
            endcase
            add_message(message);
         end
         if ($urandom_range(3) == 0) add_drain();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (job_q.size() != 0 || start || csr_valid || busy || n_issued != n_done);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (errors == 0 && power_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
